// ===== rtl/core/sps_pkg.sv =====
`timescale 1ns / 1ps

package sps_pkg;

  // default geometry
  localparam int unsigned ANGLE_BITS_DEF      = 16;
  localparam int unsigned SINE_TABLE_BITS_DEF = 10;

  // field and register widths
  localparam int unsigned ANGLE_W   = 16;
  localparam int unsigned DUTY_W    = 16;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned SINE_W    = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MOD_DEPTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD = 1'b1;

  // register reset values
  localparam logic [CFG_W-1:0] MOD_DEPTH_RST  = 16'd1638;
  localparam logic [CFG_W-1:0] PWM_PERIOD_RST = 16'd512;

  // phases and pipeline depth (table read plus four arithmetic stages)
  localparam int unsigned NUM_PHASES = 3;
  localparam int unsigned PIPE_DEPTH = 5;

  // odd taylor coefficients of sin(pi/2 * x) in q30
  localparam longint Q30_ONE = 64'sd1 << 30;
  localparam longint TAYLOR_Q30 [7] = '{
    64'sd1686629713, -64'sd693598668, 64'sd85569306, -64'sd5026995,
    64'sd172272, -64'sd3864, 64'sd61
  };

  // per-stage control shared by the duty lanes
  typedef struct packed {
    logic             en;
    logic [CFG_W-1:0] mod_depth;
    logic [CFG_W-1:0] pwm_period;
  } sps_ctrl_t;

  // quarter-wave sine entry k in q15, evaluated at elaboration
  function automatic logic [SINE_W-1:0] sine_entry(int unsigned k, int unsigned tbits);
    longint x;
    longint x2;
    longint acc;
    longint v;
    x   = longint'(k) << (30 - tbits);
    x2  = (x * x) / Q30_ONE;
    acc = TAYLOR_Q30[6];
    for (int n = 5; n >= 0; n--) begin
      acc = TAYLOR_Q30[n] + (acc * x2) / Q30_ONE;
    end
    v = (acc * x) / Q30_ONE;
    if (v < 0) v = 0;
    v = (v + (64'sd1 << 14)) >>> 15;
    if (v > 32768) v = 32768;
    if (k == 0) v = 0;
    if (k == (32'd1 << tbits)) v = 32768;
    return SINE_W'(v);
  endfunction

endpackage

// ===== rtl/core/three_phase_sine_pwm.sv =====
`timescale 1ns / 1ps

// Three-phase sine PWM duty generator.
// Slave stream: one beat per electrical angle, a full turn is 2^ANGLE_BITS.
// Master stream: one beat per angle carrying the three compare values,
// phase B leading and phase C lagging phase A by a third of a turn.
// Throughput is one beat per cycle: the quarter-wave table is read through
// two synchronous ROM copies (three read ports) and each phase has its own
// multiply lanes, so nothing is shared between consecutive angles.
// Registered steps from an accepted slave beat to master tvalid: table
// read, depth multiply, bracket add, period multiply, saturate.
// When the receiver stalls the whole pipeline freezes and the result beat
// is held; s_axis_tready follows m_axis_tready while a result is waiting.
// Reset empties the pipeline and sets mod_depth to 1638 and pwm_period to
// 512. The table is constant, so no fill pass follows reset.
// Configuration writes take effect at once and belong to idle periods.

module three_phase_sine_pwm
  import sps_pkg::*;
#(
  parameter int unsigned ANGLE_BITS      = ANGLE_BITS_DEF,
  parameter int unsigned SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration write port
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [CFG_W-1:0]          cfg_wdata_i,
  // slave stream
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [ANGLE_W-1:0]        s_axis_tdata,   // [15:0] angle
  // master stream
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [3*DUTY_W-1:0]       m_axis_tdata    // [15:0] duty_a, [31:16] duty_b, [47:32] duty_c
);

  localparam int unsigned AB = ANGLE_BITS;
  localparam int unsigned TB = SINE_TABLE_BITS;
  localparam int          SHIFT = int'(AB) - 2 - int'(TB);
  localparam logic [AB-1:0] THIRD_TURN = AB'(((64'd1 << AB) + 64'd1) / 64'd3);
  localparam logic [TB:0]   TBL_FULL   = (TB + 1)'(1) << TB;

  logic [CFG_W-1:0]      mod_depth_q, mod_depth_d;
  logic [CFG_W-1:0]      pwm_period_q, pwm_period_d;
  logic [PIPE_DEPTH-1:0] vld_q;
  logic                  en;
  sps_ctrl_t             ctrl;

  logic [AB-1:0]     angle_w;
  logic [AB-1:0]     phase_w [NUM_PHASES];
  logic [1:0]        quad_w  [NUM_PHASES];
  logic [AB-3:0]     pos_w   [NUM_PHASES];
  logic [TB-1:0]     idx_w   [NUM_PHASES];
  logic [TB:0]       addr_w  [NUM_PHASES];
  logic [NUM_PHASES-1:0] neg_q;

  logic [1:0][TB:0]        ab_addr;
  logic [0:0][TB:0]        c_addr;
  logic [1:0][SINE_W-1:0]  ab_data;
  logic [0:0][SINE_W-1:0]  c_data;
  logic [SINE_W-1:0]       mag_w  [NUM_PHASES];
  logic [DUTY_W-1:0]       duty_w [NUM_PHASES];

  // configuration registers
  always_comb begin
    mod_depth_d  = mod_depth_q;
    pwm_period_d = pwm_period_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MOD_DEPTH:  mod_depth_d  = cfg_wdata_i;
        REG_PWM_PERIOD: pwm_period_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_depth_q  <= MOD_DEPTH_RST;
      pwm_period_q <= PWM_PERIOD_RST;
    end else begin
      mod_depth_q  <= mod_depth_d;
      pwm_period_q <= pwm_period_d;
    end
  end

  // pipeline advances unless a result beat is stuck at the output
  assign en            = !vld_q[PIPE_DEPTH-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[PIPE_DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], s_axis_tvalid};
    end
  end

  assign ctrl.en         = en;
  assign ctrl.mod_depth  = mod_depth_q;
  assign ctrl.pwm_period = pwm_period_q;

  // angle to the working width
  generate
    if (AB <= ANGLE_W) begin : g_angle_trunc
      assign angle_w = s_axis_tdata[AB-1:0];
    end else begin : g_angle_ext
      assign angle_w = {{(AB - ANGLE_W){1'b0}}, s_axis_tdata};
    end
  endgenerate

  // the three phase angles, wrapping modulo a turn
  assign phase_w[0] = angle_w;
  assign phase_w[1] = angle_w + THIRD_TURN;
  assign phase_w[2] = angle_w - THIRD_TURN;

  // quadrant split and table address per phase
  for (genvar p = 0; p < NUM_PHASES; p++) begin : g_addr
    assign quad_w[p] = phase_w[p][AB-1:AB-2];
    assign pos_w[p]  = phase_w[p][AB-3:0];
    if (SHIFT >= 0) begin : g_drop
      assign idx_w[p] = pos_w[p][AB-3:SHIFT];
    end else begin : g_pad
      assign idx_w[p] = {pos_w[p], {(-SHIFT){1'b0}}};
    end
    assign addr_w[p] = quad_w[p][0] ? (TBL_FULL - {1'b0, idx_w[p]}) : {1'b0, idx_w[p]};
  end

  // sign of each phase travels beside the table read
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int p = 0; p < NUM_PHASES; p++) begin
        neg_q[p] <= quad_w[p][1];
      end
    end
  end

  // two table copies give three read ports
  assign ab_addr[0] = addr_w[0];
  assign ab_addr[1] = addr_w[1];
  assign c_addr[0]  = addr_w[2];

  sps_sine_rom #(
    .TABLE_BITS (TB),
    .PORTS      (2)
  ) u_rom_ab (
    .clk_i  (clk_i),
    .en_i   (en),
    .addr_i (ab_addr),
    .data_o (ab_data)
  );

  sps_sine_rom #(
    .TABLE_BITS (TB),
    .PORTS      (1)
  ) u_rom_c (
    .clk_i  (clk_i),
    .en_i   (en),
    .addr_i (c_addr),
    .data_o (c_data)
  );

  assign mag_w[0] = ab_data[0];
  assign mag_w[1] = ab_data[1];
  assign mag_w[2] = c_data[0];

  // duty lanes
  for (genvar p = 0; p < NUM_PHASES; p++) begin : g_duty
    sps_duty u_duty (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .mag_i  (mag_w[p]),
      .neg_i  (neg_q[p]),
      .duty_o (duty_w[p])
    );
  end

  assign m_axis_tdata = {duty_w[2], duty_w[1], duty_w[0]};

  // checks on the stall logic and valid pipeline
  a_stall_only_on_blocked_output : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready)
  ) else $error("slave side stalled without a blocked result beat");

  a_valid_shifts_on_advance : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    en |=> (vld_q[PIPE_DEPTH-1:1] == $past(vld_q[PIPE_DEPTH-2:0]))
  ) else $error("valid pipeline did not shift on advance");

  a_valid_frozen_on_stall : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q)
  ) else $error("valid pipeline moved while stalled");

  a_accept_enters_pipe : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> vld_q[0]
  ) else $error("accepted beat not entered in the pipeline");

endmodule

// ===== rtl/core/sps_sine_rom.sv =====
`timescale 1ns / 1ps

module sps_sine_rom
  import sps_pkg::*;
#(
  parameter int unsigned TABLE_BITS = SINE_TABLE_BITS_DEF,
  parameter int unsigned PORTS      = 2
) (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic [PORTS-1:0][TABLE_BITS:0]   addr_i,
  output logic [PORTS-1:0][SINE_W-1:0]     data_o
);

  localparam int unsigned DEPTH = (1 << TABLE_BITS) + 1;

  typedef logic [SINE_W-1:0] rom_t [DEPTH];

  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k < DEPTH; k++) begin
      r[k] = sine_entry(k, TABLE_BITS);
    end
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  logic [PORTS-1:0][SINE_W-1:0] data_q;

  // registered reads, held while the pipeline is stalled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int p = 0; p < PORTS; p++) begin
        data_q[p] <= ROM[addr_i[p]];
      end
    end
  end

  assign data_o = data_q;

endmodule

// ===== rtl/core/sps_duty.sv =====
`timescale 1ns / 1ps

module sps_duty
  import sps_pkg::*;
(
  input  logic              clk_i,
  input  sps_ctrl_t         ctrl_i,
  input  logic [SINE_W-1:0] mag_i,
  input  logic              neg_i,
  output logic [DUTY_W-1:0] duty_o
);

  localparam int unsigned PROD_W  = CFG_W + SINE_W;
  localparam int unsigned BRACK_W = 32;
  localparam int unsigned SCALE_W = BRACK_W + CFG_W;

  localparam logic signed [BRACK_W:0] HALF_Q31 = (BRACK_W + 1)'(64'd1 << 30);

  logic [PROD_W-1:0]        prod_q;
  logic                     neg_q;
  logic signed [BRACK_W:0]  sum_w;
  logic [BRACK_W-1:0]       bracket_q;
  logic [SCALE_W-1:0]       scaled_q;
  logic [DUTY_W:0]          raw_w;
  logic [DUTY_W-1:0]        duty_q;

  // depth times sine magnitude
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      prod_q <= ctrl_i.mod_depth * mag_i;
      neg_q  <= neg_i;
    end
  end

  // one half plus depth times sine, floored at zero
  always_comb begin
    if (neg_q) begin
      sum_w = HALF_Q31 - $signed({1'b0, prod_q});
    end else begin
      sum_w = HALF_Q31 + $signed({1'b0, prod_q});
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      bracket_q <= sum_w[BRACK_W] ? '0 : sum_w[BRACK_W-1:0];
    end
  end

  // scale by the period
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      scaled_q <= bracket_q * ctrl_i.pwm_period;
    end
  end

  // drop the q31 fraction and saturate at the period
  assign raw_w = scaled_q[SCALE_W-1:31];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      duty_q <= (raw_w > {1'b0, ctrl_i.pwm_period}) ? ctrl_i.pwm_period : raw_w[DUTY_W-1:0];
    end
  end

  assign duty_o = duty_q;

endmodule
